// ===== hdl/tjpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tjpc_pkg;

    // Stream payload widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_USED_W  = 17;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 8;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MAIN_GREEN = 3'd0;
    localparam logic [2:0] REG_MAIN_AMBER = 3'd1;
    localparam logic [2:0] REG_SIDE_GREEN = 3'd2;
    localparam logic [2:0] REG_SIDE_AMBER = 3'd3;
    localparam logic [2:0] REG_WALK_GREEN = 3'd4;
    localparam logic [2:0] REG_WALK_BLINK = 3'd5;
    localparam logic [2:0] REG_TURN_GREEN = 3'd6;
    localparam logic [2:0] REG_TURN_BLINK = 3'd7;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_MAIN_GREEN = 8'd10;
    localparam logic [CFG_W-1:0] RST_MAIN_AMBER = 8'd3;
    localparam logic [CFG_W-1:0] RST_SIDE_GREEN = 8'd10;
    localparam logic [CFG_W-1:0] RST_SIDE_AMBER = 8'd3;
    localparam logic [CFG_W-1:0] RST_WALK_GREEN = 8'd8;
    localparam logic [CFG_W-1:0] RST_WALK_BLINK = 8'd3;
    localparam logic [CFG_W-1:0] RST_TURN_GREEN = 8'd6;
    localparam logic [CFG_W-1:0] RST_TURN_BLINK = 8'd3;

    // Vehicle lamp codes
    localparam logic [1:0] LAMP_STOP  = 2'd0;
    localparam logic [1:0] LAMP_AMBER = 2'd1;
    localparam logic [1:0] LAMP_GO    = 2'd2;

    // Pedestrian and turn lamp codes
    localparam logic [1:0] SIG_RED   = 2'd0;
    localparam logic [1:0] SIG_GREEN = 2'd1;
    localparam logic [1:0] SIG_BLINK = 2'd2;

    // Phase codes as they appear on the result stream
    localparam logic [2:0] PHC_MAIN       = 3'd0;
    localparam logic [2:0] PHC_MAIN_AMBER = 3'd1;
    localparam logic [2:0] PHC_WALK       = 3'd2;
    localparam logic [2:0] PHC_WALK_BLINK = 3'd3;
    localparam logic [2:0] PHC_SIDE       = 3'd4;
    localparam logic [2:0] PHC_SIDE_AMBER = 3'd5;
    localparam logic [2:0] PHC_TURN       = 3'd6;
    localparam logic [2:0] PHC_TURN_BLINK = 3'd7;

    typedef enum logic [7:0] {
        PH_MAIN       = 8'b0000_0001,
        PH_MAIN_AMBER = 8'b0000_0010,
        PH_WALK       = 8'b0000_0100,
        PH_WALK_BLINK = 8'b0000_1000,
        PH_SIDE       = 8'b0001_0000,
        PH_SIDE_AMBER = 8'b0010_0000,
        PH_TURN       = 8'b0100_0000,
        PH_TURN_BLINK = 8'b1000_0000
    } phase_t;

    // First member lands in the top bits, so main_a sits lowest.
    typedef struct packed {
        logic [1:0] turn_four;
        logic [1:0] turn_two;
        logic [1:0] walk_b;
        logic [1:0] walk_a;
        logic [1:0] side;
        logic [1:0] main_b;
        logic [1:0] main_a;
    } lamps_t;

    localparam lamps_t LAMPS_RESET = '{
        turn_four: SIG_RED,
        turn_two:  SIG_RED,
        walk_b:    SIG_GREEN,
        walk_a:    SIG_RED,
        side:      LAMP_STOP,
        main_b:    LAMP_GO,
        main_a:    LAMP_GO
    };

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_MAIN:       code = PHC_MAIN;
            PH_MAIN_AMBER: code = PHC_MAIN_AMBER;
            PH_WALK:       code = PHC_WALK;
            PH_WALK_BLINK: code = PHC_WALK_BLINK;
            PH_SIDE:       code = PHC_SIDE;
            PH_SIDE_AMBER: code = PHC_SIDE_AMBER;
            PH_TURN:       code = PHC_TURN;
            PH_TURN_BLINK: code = PHC_TURN_BLINK;
            default:       code = PHC_MAIN;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/traffic_junction_phase_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Traffic junction phase controller.
// Input stream (s_*): one transaction per tick, s_tdata[0] = pedestrian button
// pulse, s_tdata[1] = turn loop hit. Each pulse sets a request latch that holds
// until the phase sequence serves it.
// Output stream (m_*): one transaction per input tick, carrying the phase code
// and seven lamp codes as they stand after that tick's update.
// Configuration: APB-style port, eight 8-bit duration registers at byte
// addresses 0, 4, ..., 28; the user must write them only while the stream is
// idle, as the block does not enforce this. Results are registered. Throughput:
// one tick per cycle when not stalled; the phase update is a single compare
// and increment between the state registers and the result register. Stall:
// the result register holds while m_tready is low, and s_tready drops until
// it is taken; when it is taken, a new tick is accepted in that cycle.
// Reset (rst_n low, asynchronous): phase main flow, both counters at 1, no
// requests, main lamps go, pedestrian lamp B green, all others red or stop,
// duration registers at their defaults, result register empty.
module traffic_junction_phase_controller #(
    parameter int COUNT_BITS = 8
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // s_tdata: [0] button_press, [1] sensor_hit, [7:2] zero
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [tjpc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // m_tdata: [2:0] phase, [4:3] lamp_main_a, [6:5] lamp_main_b,
    // [8:7] lamp_side, [10:9] walk_lamp_a, [12:11] walk_lamp_b,
    // [14:13] turn_lamp_two, [16:15] turn_lamp_four, [23:17] zero
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [tjpc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [tjpc_pkg::ADDR_W-1:0]         paddr,
    input  wire  [tjpc_pkg::DATA_W-1:0]         pwdata,
    output logic [tjpc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import tjpc_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // Duration registers
    logic [CFG_W-1:0] main_green_reg;
    logic [CFG_W-1:0] main_amber_reg;
    logic [CFG_W-1:0] side_green_reg;
    logic [CFG_W-1:0] side_amber_reg;
    logic [CFG_W-1:0] walk_green_reg;
    logic [CFG_W-1:0] walk_blink_reg;
    logic [CFG_W-1:0] turn_green_reg;
    logic [CFG_W-1:0] turn_blink_reg;

    // Phase state
    phase_t                  phase_reg,    phase_next;
    logic [COUNT_BITS-1:0]   green_cnt_reg, green_cnt_next;
    logic [COUNT_BITS-1:0]   amber_cnt_reg, amber_cnt_next;
    logic                    walk_req_reg,  walk_req_next;
    logic                    turn_req_reg,  turn_req_next;
    lamps_t                  lamps_reg,     lamps_next;

    // Result register
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;

    logic                    in_fire;
    logic                    cfg_write;
    logic [2:0]              cfg_idx;
    logic                    walk_set;
    logic                    turn_set;
    logic                    green_done;
    logic                    amber_done;
    logic [CFG_W-1:0]        green_lim;
    logic [CFG_W-1:0]        amber_lim;

    // A phase ends once its counter reaches the limit, or at counter saturation.
    function automatic logic count_done(input logic [COUNT_BITS-1:0] cnt,
                                        input logic [CFG_W-1:0] lim);
        return (CMP_W'(cnt) >= CMP_W'(lim)) || (cnt == {COUNT_BITS{1'b1}});
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[4:2];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Latch this tick's pulses before the phase logic looks at them.
    assign walk_set = walk_req_reg || s_tdata[0];
    assign turn_set = turn_req_reg || s_tdata[1];

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_green_reg <= RST_MAIN_GREEN;
            main_amber_reg <= RST_MAIN_AMBER;
            side_green_reg <= RST_SIDE_GREEN;
            side_amber_reg <= RST_SIDE_AMBER;
            walk_green_reg <= RST_WALK_GREEN;
            walk_blink_reg <= RST_WALK_BLINK;
            turn_green_reg <= RST_TURN_GREEN;
            turn_blink_reg <= RST_TURN_BLINK;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MAIN_GREEN: main_green_reg <= pwdata[CFG_W-1:0];
                REG_MAIN_AMBER: main_amber_reg <= pwdata[CFG_W-1:0];
                REG_SIDE_GREEN: side_green_reg <= pwdata[CFG_W-1:0];
                REG_SIDE_AMBER: side_amber_reg <= pwdata[CFG_W-1:0];
                REG_WALK_GREEN: walk_green_reg <= pwdata[CFG_W-1:0];
                REG_WALK_BLINK: walk_blink_reg <= pwdata[CFG_W-1:0];
                REG_TURN_GREEN: turn_green_reg <= pwdata[CFG_W-1:0];
                REG_TURN_BLINK: turn_blink_reg <= pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    // Configuration read
    always_comb
    begin
        case (cfg_idx)
            REG_MAIN_GREEN: prdata = DATA_W'(main_green_reg);
            REG_MAIN_AMBER: prdata = DATA_W'(main_amber_reg);
            REG_SIDE_GREEN: prdata = DATA_W'(side_green_reg);
            REG_SIDE_AMBER: prdata = DATA_W'(side_amber_reg);
            REG_WALK_GREEN: prdata = DATA_W'(walk_green_reg);
            REG_WALK_BLINK: prdata = DATA_W'(walk_blink_reg);
            REG_TURN_GREEN: prdata = DATA_W'(turn_green_reg);
            REG_TURN_BLINK: prdata = DATA_W'(turn_blink_reg);
            default:        prdata = '0;
        endcase
    end

    // Pick the limit that the current phase compares against.
    always_comb
    begin
        case (phase_reg)
            PH_MAIN:       green_lim = main_green_reg;
            PH_WALK:       green_lim = walk_green_reg;
            PH_SIDE:       green_lim = side_green_reg;
            PH_TURN:       green_lim = turn_green_reg;
            default:       green_lim = main_green_reg;
        endcase
        case (phase_reg)
            PH_MAIN_AMBER: amber_lim = main_amber_reg;
            PH_WALK_BLINK: amber_lim = walk_blink_reg;
            PH_SIDE_AMBER: amber_lim = side_amber_reg;
            PH_TURN_BLINK: amber_lim = turn_blink_reg;
            default:       amber_lim = main_amber_reg;
        endcase
    end

    assign green_done = count_done(green_cnt_reg, green_lim);
    assign amber_done = count_done(amber_cnt_reg, amber_lim);

    // Phase sequencing
    always_comb
    begin
        phase_next     = phase_reg;
        green_cnt_next = green_cnt_reg;
        amber_cnt_next = amber_cnt_reg;
        walk_req_next  = walk_set;
        turn_req_next  = turn_set;
        lamps_next     = lamps_reg;

        case (phase_reg)
            PH_MAIN:
            begin
                // A pending walk request cuts main flow short.
                if (walk_set || green_done)
                begin
                    green_cnt_next    = CNT_ONE;
                    phase_next        = PH_MAIN_AMBER;
                    lamps_next.main_a = LAMP_AMBER;
                    lamps_next.main_b = LAMP_AMBER;
                    lamps_next.walk_b = SIG_BLINK;
                end
                else
                begin
                    green_cnt_next = green_cnt_reg + CNT_ONE;
                end
            end
            PH_MAIN_AMBER:
            begin
                if (amber_done)
                begin
                    amber_cnt_next      = CNT_ONE;
                    lamps_next.main_a   = LAMP_STOP;
                    lamps_next.main_b   = LAMP_STOP;
                    lamps_next.walk_b   = SIG_RED;
                    lamps_next.turn_two = SIG_GREEN;
                    if (walk_set)
                    begin
                        walk_req_next     = 1'b0;
                        phase_next        = PH_WALK;
                        lamps_next.walk_a = SIG_GREEN;
                    end
                    else
                    begin
                        phase_next      = PH_SIDE;
                        lamps_next.side = LAMP_GO;
                    end
                end
                else
                begin
                    amber_cnt_next = amber_cnt_reg + CNT_ONE;
                end
            end
            PH_WALK:
            begin
                if (green_done)
                begin
                    green_cnt_next    = CNT_ONE;
                    phase_next        = PH_WALK_BLINK;
                    lamps_next.walk_a = SIG_BLINK;
                end
                else
                begin
                    green_cnt_next = green_cnt_reg + CNT_ONE;
                end
            end
            PH_WALK_BLINK:
            begin
                if (amber_done)
                begin
                    amber_cnt_next    = CNT_ONE;
                    phase_next        = PH_SIDE;
                    lamps_next.walk_a = SIG_RED;
                    lamps_next.side   = LAMP_GO;
                end
                else
                begin
                    amber_cnt_next = amber_cnt_reg + CNT_ONE;
                end
            end
            PH_SIDE:
            begin
                if (green_done)
                begin
                    green_cnt_next      = CNT_ONE;
                    phase_next          = PH_SIDE_AMBER;
                    lamps_next.side     = LAMP_AMBER;
                    lamps_next.turn_two = SIG_BLINK;
                end
                else
                begin
                    green_cnt_next = green_cnt_reg + CNT_ONE;
                end
            end
            PH_SIDE_AMBER:
            begin
                if (amber_done)
                begin
                    amber_cnt_next      = CNT_ONE;
                    lamps_next.side     = LAMP_STOP;
                    lamps_next.turn_two = SIG_RED;
                    lamps_next.main_a   = LAMP_GO;
                    if (turn_set)
                    begin
                        turn_req_next        = 1'b0;
                        phase_next           = PH_TURN;
                        lamps_next.turn_four = SIG_GREEN;
                    end
                    else
                    begin
                        phase_next        = PH_MAIN;
                        lamps_next.walk_b = SIG_GREEN;
                        lamps_next.main_b = LAMP_GO;
                    end
                end
                else
                begin
                    amber_cnt_next = amber_cnt_reg + CNT_ONE;
                end
            end
            PH_TURN:
            begin
                if (green_done)
                begin
                    green_cnt_next       = CNT_ONE;
                    phase_next           = PH_TURN_BLINK;
                    lamps_next.turn_four = SIG_BLINK;
                end
                else
                begin
                    green_cnt_next = green_cnt_reg + CNT_ONE;
                end
            end
            PH_TURN_BLINK:
            begin
                if (amber_done)
                begin
                    amber_cnt_next       = CNT_ONE;
                    phase_next           = PH_MAIN;
                    lamps_next.turn_four = SIG_RED;
                    lamps_next.main_b    = LAMP_GO;
                    lamps_next.walk_b    = SIG_GREEN;
                end
                else
                begin
                    amber_cnt_next = amber_cnt_reg + CNT_ONE;
                end
            end
            default:
            begin
                // Not reachable from reset; hold phase, counters and lamps.
                phase_next = phase_reg;
            end
        endcase
    end

    // Advance the state on each accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAIN;
            green_cnt_reg <= CNT_ONE;
            amber_cnt_reg <= CNT_ONE;
            walk_req_reg  <= 1'b0;
            turn_req_reg  <= 1'b0;
            lamps_reg     <= LAMPS_RESET;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            green_cnt_reg <= green_cnt_next;
            amber_cnt_reg <= amber_cnt_next;
            walk_req_reg  <= walk_req_next;
            turn_req_reg  <= turn_req_next;
            lamps_reg     <= lamps_next;
        end
    end

    // Result register: load on accept, drop valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            m_tdata_reg <= {(OUT_TDATA_W - OUT_USED_W)'(0), lamps_next,
                            phase_code(phase_next)};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tjpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tjpc_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    input  wire                                 s_tready,
    input  wire                                 m_tvalid,
    input  wire                                 m_tready,
    input  wire  [tjpc_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import tjpc_pkg::*;

    // Every accepted tick produces a result in the next cycle.
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted tick produced no result");

    // A stalled result blocks new ticks.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Main flow always shows main road go and side road stop.
    a_main_lamps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == PHC_MAIN)
            |-> (m_tdata[4:3] == LAMP_GO) && (m_tdata[8:7] == LAMP_STOP))
        else $error("main flow with conflicting lamps");

endmodule

bind traffic_junction_phase_controller tjpc_checker u_tjpc_checker (.*);

`default_nettype wire
